[sv/md5_pkg.sv]
// Shared types, constants and round functions of the MD5 stream hasher.
`default_nettype none
package md5_pkg;
	localparam logic [31:0] INIT_A = 32'h67452301;
	localparam logic [31:0] INIT_B = 32'hefcdab89;
	localparam logic [31:0] INIT_C = 32'h98badcfe;
	localparam logic [31:0] INIT_D = 32'h10325476;
	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [5:0] LEN_OFFSET = 6'd56;

	localparam logic [1:0] WSEL_ZERO = 2'd0;
	localparam logic [1:0] WSEL_BYTE = 2'd1;
	localparam logic [1:0] WSEL_PAD = 2'd2;
	localparam logic [1:0] WSEL_LEN = 2'd3;

	typedef struct packed {
		logic       buf_we;
		logic [1:0] wsel;
		logic [5:0] waddr;
		logic       cnt_inc;
		logic       round_start;
		logic       round_step;
		logic       chain_add;
		logic       chain_init;
		logic       latch_len;
	} md5_cmd_t;

	typedef struct packed {
		logic       round_last;
		logic [5:0] offset;
	} md5_sts_t;

	localparam logic [31:0] K_TAB [64] = '{
		32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
		32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
		32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
		32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
		32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
		32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
		32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
		32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
		32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
		32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
		32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
		32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
		32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
		32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
		32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
		32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
	};

	localparam logic [4:0] S_TAB [16] = '{
		5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
		5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
	};

	function automatic logic [3:0] msg_index(input logic [5:0] r);
		logic [5:0] g;
		begin
			case (r[5:4])
				2'd0: g = r;
				2'd1: g = 6'(5 * r + 1);
				2'd2: g = 6'(3 * r + 5);
				default: g = 6'(7 * r);
			endcase
			return g[3:0];
		end
	endfunction

	function automatic logic [31:0] bool_fn(input logic [1:0] ph, input logic [31:0] b,
		input logic [31:0] c, input logic [31:0] d);
		case (ph)
			2'd0: return (b & c) | (~b & d);
			2'd1: return (b & d) | (c & ~d);
			2'd2: return b ^ c ^ d;
			default: return c ^ (b | ~d);
		endcase
	endfunction
endpackage
`default_nettype wire

[sv/md5_datapath.sv]
// Block buffer, length counter, round engine and chaining words of the MD5 hasher.
`default_nettype none
module md5_datapath
	import md5_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire md5_cmd_t    cmd,
	input  wire logic [7:0]  data_byte,
	output md5_sts_t         sts,
	output logic [127:0]     digest
);
	logic [31:0] buf_q [16];
	logic [63:0] total_q;
	logic [63:0] bits_q;
	logic [31:0] h_q [4];
	logic [31:0] a_q, b_q, c_q, d_q;
	logic [5:0]  r_q;
	logic [7:0]  wbyte;
	logic [3:0]  g;
	logic [31:0] w;
	logic [31:0] sum;
	logic [4:0]  s;
	logic [31:0] rot;
	logic [31:0] b_new;

	always_comb begin
		case (cmd.wsel)
			WSEL_BYTE: wbyte = data_byte;
			WSEL_PAD: wbyte = PAD_BYTE;
			WSEL_LEN: wbyte = bits_q[{cmd.waddr[2:0], 3'b000} +: 8];
			default: wbyte = 8'h00;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.buf_we) begin
			buf_q[cmd.waddr[5:2]][{cmd.waddr[1:0], 3'b000} +: 8] <= wbyte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
		end else if (cmd.chain_init) begin
			total_q <= '0;
		end else if (cmd.cnt_inc) begin
			total_q <= total_q + 64'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_len) begin
			bits_q <= {total_q[60:0], 3'b000};
		end
	end

	assign g = msg_index(r_q);
	assign w = buf_q[g];
	assign sum = a_q + bool_fn(r_q[5:4], b_q, c_q, d_q) + K_TAB[r_q] + w;
	assign s = S_TAB[{r_q[5:4], r_q[1:0]}];
	assign rot = (sum << s) | (sum >> (6'd32 - {1'b0, s}));
	assign b_new = b_q + rot;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_q <= '0;
		end else if (cmd.round_start) begin
			r_q <= '0;
		end else if (cmd.round_step) begin
			r_q <= r_q + 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.round_start) begin
			a_q <= h_q[0];
			b_q <= h_q[1];
			c_q <= h_q[2];
			d_q <= h_q[3];
		end else if (cmd.round_step) begin
			a_q <= d_q;
			b_q <= b_new;
			c_q <= b_q;
			d_q <= c_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q[0] <= INIT_A;
			h_q[1] <= INIT_B;
			h_q[2] <= INIT_C;
			h_q[3] <= INIT_D;
		end else if (cmd.chain_init) begin
			h_q[0] <= INIT_A;
			h_q[1] <= INIT_B;
			h_q[2] <= INIT_C;
			h_q[3] <= INIT_D;
		end else if (cmd.chain_add) begin
			h_q[0] <= h_q[0] + a_q;
			h_q[1] <= h_q[1] + b_q;
			h_q[2] <= h_q[2] + c_q;
			h_q[3] <= h_q[3] + d_q;
		end
	end

	always_comb begin
		for (int i = 0; i < 16; i++) begin
			digest[127 - 8 * i -: 8] = h_q[i / 4][8 * (i % 4) +: 8];
		end
	end

	assign sts.round_last = (r_q == 6'd63);
	assign sts.offset = total_q[5:0];
endmodule
`default_nettype wire

[sv/md5_ctrl.sv]
// Control state machine of the MD5 hasher: intake, padding, rounds and digest output.
`default_nettype none
module md5_ctrl
	import md5_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        byte_present,
	input  wire logic        end_of_message,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             out_part,
	output md5_cmd_t         cmd,
	input  wire md5_sts_t    sts
);
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_ROUND = 3'd1;
	localparam logic [2:0] ST_ADD   = 3'd2;
	localparam logic [2:0] ST_PAD   = 3'd3;
	localparam logic [2:0] ST_LEN   = 3'd4;
	localparam logic [2:0] ST_OUT   = 3'd5;

	logic [2:0] state_q;
	logic       fin_q;
	logic       final_q;
	logic       eom_q;
	logic [5:0] ptr_q;
	logic       part_q;
	logic       acc;

	assign in_ready = (state_q == ST_IDLE);
	assign acc = in_valid && in_ready;
	assign out_valid = (state_q == ST_OUT);
	assign out_part = part_q;

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.waddr = sts.offset;
				cmd.wsel = WSEL_BYTE;
				if (acc && byte_present) begin
					cmd.buf_we = 1'b1;
					cmd.cnt_inc = 1'b1;
					cmd.round_start = (sts.offset == 6'd63);
				end
			end
			ST_ROUND: begin
				cmd.round_step = 1'b1;
			end
			ST_ADD: begin
				cmd.chain_add = 1'b1;
			end
			ST_PAD: begin
				cmd.buf_we = 1'b1;
				cmd.latch_len = 1'b1;
				cmd.waddr = ptr_q;
				cmd.wsel = (ptr_q == sts.offset && !fin_q) ? WSEL_PAD : WSEL_ZERO;
				if (ptr_q == 6'd63 || (fin_q && ptr_q == LEN_OFFSET - 6'd1)) begin
					cmd.round_start = fin_q || (sts.offset >= LEN_OFFSET);
				end
			end
			ST_LEN: begin
				cmd.buf_we = 1'b1;
				cmd.waddr = ptr_q;
				cmd.wsel = WSEL_LEN;
				cmd.round_start = (ptr_q == 6'd63);
			end
			ST_OUT: begin
				if (out_ready && part_q) begin
					cmd.chain_init = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fin_q <= 1'b0;
			final_q <= 1'b0;
			eom_q <= 1'b0;
			ptr_q <= '0;
			part_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (acc) begin
						eom_q <= end_of_message;
						fin_q <= 1'b0;
						final_q <= 1'b0;
						ptr_q <= sts.offset + 6'd1;
						if (byte_present && sts.offset == 6'd63) begin
							state_q <= ST_ROUND;
						end else if (end_of_message) begin
							state_q <= ST_PAD;
							ptr_q <= byte_present ? sts.offset + 6'd1 : sts.offset;
						end
					end
				end
				ST_ROUND: begin
					if (sts.round_last) begin
						state_q <= ST_ADD;
					end
				end
				ST_ADD: begin
					if (final_q) begin
						state_q <= ST_OUT;
						part_q <= 1'b0;
					end else if (eom_q) begin
						state_q <= ST_PAD;
						ptr_q <= fin_q ? 6'd0 : sts.offset;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_PAD: begin
					if (eom_q && !fin_q && ptr_q == sts.offset) begin
						eom_q <= 1'b1;
					end
					if (fin_q && ptr_q == LEN_OFFSET - 6'd1) begin
						ptr_q <= LEN_OFFSET;
						state_q <= ST_LEN;
						fin_q <= 1'b0;
					end else if (ptr_q == 6'd63) begin
						if (sts.offset >= LEN_OFFSET) begin
							state_q <= ST_ROUND;
							fin_q <= 1'b1;
						end else begin
							ptr_q <= LEN_OFFSET;
							state_q <= ST_LEN;
						end
					end else begin
						ptr_q <= ptr_q + 6'd1;
					end
				end
				ST_LEN: begin
					if (ptr_q == 6'd63) begin
						state_q <= ST_ROUND;
						final_q <= 1'b1;
					end else begin
						ptr_q <= ptr_q + 6'd1;
					end
				end
				ST_OUT: begin
					if (out_ready) begin
						if (part_q) begin
							state_q <= ST_IDLE;
							eom_q <= 1'b0;
						end
						part_q <= ~part_q;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

[sv/md5_stream_hasher.sv]
// Top level of the MD5 stream hasher: controller and datapath.
// Channel  | Dir | tdata                      | tuser      | tlast
// s_axis   | in  | [7:0] data_byte            | byte_present | end_of_message
// m_axis   | out | [63:0] digest_part         | part_index | last_part
// One byte per request is taken while idle; a full 64-byte block then holds the
// input while the single round unit runs the rounds and the chaining add.
// End of message writes pad and length bytes one per cycle and runs one or two
// more compressions, then two digest requests leave in turn.
// Reset restores the MD5 initial chaining words and clears the length count.
// A stalled output holds the digest; no input is taken until both parts are gone.
`default_nettype none
module md5_stream_hasher
	import md5_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,  // [7:0] data_byte
	input  wire logic        s_axis_tuser,  // byte_present
	input  wire logic        s_axis_tlast,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [63:0]      m_axis_tdata,  // [63:0] digest_part
	output logic             m_axis_tuser,  // part_index
	output logic             m_axis_tlast
);
	md5_cmd_t     cmd;
	md5_sts_t     sts;
	logic [127:0] digest;
	logic         out_part;

	md5_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (s_axis_tvalid),
		.in_ready      (s_axis_tready),
		.byte_present  (s_axis_tuser),
		.end_of_message(s_axis_tlast),
		.out_valid     (m_axis_tvalid),
		.out_ready     (m_axis_tready),
		.out_part      (out_part),
		.cmd           (cmd),
		.sts           (sts)
	);

	md5_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.data_byte(s_axis_tdata),
		.sts      (sts),
		.digest   (digest)
	);

	assign m_axis_tdata = out_part ? digest[63:0] : digest[127:64];
	assign m_axis_tuser = out_part;
	assign m_axis_tlast = out_part;
endmodule
`default_nettype wire

[tb/sv/md5_stream_hasher_tb.sv]
// Testbench of the MD5 stream hasher: random byte streams checked against a built-in MD5 predictor.
`default_nettype none
module md5_stream_hasher_tb;
	import md5_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_present;
		logic       end_of_message;
	} byte_req_t;

	typedef struct packed {
		logic [63:0] digest_part;
		logic        part_index;
		logic        last_part;
	} digest_req_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [7:0] s_axis_tdata = '0;
	logic s_axis_tuser = 1'b0;
	logic s_axis_tlast = 1'b0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [63:0] m_axis_tdata;
	logic m_axis_tuser;
	logic m_axis_tlast;

	byte_req_t pending_bytes[$];
	digest_req_t expected_digests[$];
	int mismatch_count = 0;
	bit stimulus_done = 1'b0;
	int send_gap = 0;
	int recv_gap = 0;

	logic [31:0] chain [4];
	logic [7:0] block [64];
	logic [63:0] total_bytes;

	md5_stream_hasher dut (.*);

	always #2 clk = ~clk;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 80);
	endfunction

	function automatic logic [31:0] rotl(input logic [31:0] v, input int s);
		return (v << s) | (v >> (32 - s));
	endfunction

	task automatic compress_block();
		logic [31:0] w [16];
		logic [31:0] a, b, c, d, f, t;
		int g;
		for (int i = 0; i < 16; i++)
			w[i] = {block[4*i+3], block[4*i+2], block[4*i+1], block[4*i]};
		a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
		for (int r = 0; r < 64; r++) begin
			case (r / 16)
				0: begin f = (b & c) | (~b & d); g = r; end
				1: begin f = (b & d) | (c & ~d); g = (5 * r + 1) % 16; end
				2: begin f = b ^ c ^ d; g = (3 * r + 5) % 16; end
				default: begin f = c ^ (b | ~d); g = (7 * r) % 16; end
			endcase
			t = d; d = c; c = b;
			b = b + rotl(a + f + K_TAB[r] + w[g], S_TAB[(r / 16) * 4 + r % 4]);
			a = t;
		end
		chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
	endtask

	task automatic restart_chain();
		chain[0] = INIT_A; chain[1] = INIT_B; chain[2] = INIT_C; chain[3] = INIT_D;
		total_bytes = '0;
	endtask

	task automatic predict_digest(input byte_req_t req);
		int off;
		logic [63:0] bit_len;
		logic [7:0] dig [16];
		digest_req_t res;
		if (req.byte_present) begin
			off = total_bytes[5:0];
			block[off] = req.data_byte;
			total_bytes++;
			if (off == 63) compress_block();
		end
		if (!req.end_of_message) return;
		off = total_bytes[5:0];
		block[off] = PAD_BYTE;
		for (int i = off + 1; i < 64; i++) block[i] = '0;
		if (off >= 56) begin
			compress_block();
			for (int i = 0; i < 56; i++) block[i] = '0;
		end
		bit_len = total_bytes << 3;
		for (int i = 0; i < 8; i++) block[56 + i] = bit_len[8*i +: 8];
		compress_block();
		for (int i = 0; i < 16; i++) dig[i] = chain[i / 4][8 * (i % 4) +: 8];
		for (int p = 0; p < 2; p++) begin
			res.digest_part = '0;
			for (int k = 0; k < 8; k++) res.digest_part = {res.digest_part[55:0], dig[8*p + k]};
			res.part_index = p[0];
			res.last_part = p[0];
			expected_digests.push_back(res);
		end
		restart_chain();
	endtask

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("mismatch %s: got %h want %h", what, got, want);
		mismatch_count++;
	endtask

	task automatic add_message(input int len, input bit trailing_empty);
		byte_req_t req;
		for (int i = 0; i < len; i++) begin
			req.data_byte = $urandom_range(0, 255);
			req.byte_present = 1'b1;
			req.end_of_message = (i == len - 1) && !trailing_empty;
			pending_bytes.push_back(req);
			if ($urandom_range(0, 19) == 0) pending_bytes.push_back('0);
		end
		if (trailing_empty || len == 0) pending_bytes.push_back(byte_req_t'{8'h00, 1'b0, 1'b1});
	endtask

	always @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			predict_digest({s_axis_tdata, s_axis_tuser, s_axis_tlast});
		end
		if (send_gap > 0 && !(s_axis_tvalid && !s_axis_tready)) begin
			send_gap <= send_gap - 1;
			s_axis_tvalid <= 1'b0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			if (arst_n && pending_bytes.size() > 0) begin
				{s_axis_tdata, s_axis_tuser, s_axis_tlast} <= pending_bytes.pop_front();
				s_axis_tvalid <= 1'b1;
				send_gap <= pick_gap();
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		digest_req_t want;
		if (m_axis_tvalid && m_axis_tready) begin
			if (expected_digests.size() == 0) begin
				report("unexpected digest", m_axis_tdata, '0);
			end else begin
				want = expected_digests.pop_front();
				if (m_axis_tdata !== want.digest_part)
					report("digest_part", m_axis_tdata, want.digest_part);
				if (m_axis_tuser !== want.part_index)
					report("part_index", m_axis_tuser, want.part_index);
				if (m_axis_tlast !== want.last_part)
					report("last_part", m_axis_tlast, want.last_part);
			end
		end
		if (recv_gap > 0) begin
			recv_gap <= recv_gap - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
			if ($urandom_range(0, 3) == 0) recv_gap <= pick_gap();
		end
	end

	initial begin
		byte_req_t req;
		restart_chain();
		for (int i = 0; i < 64; i++) block[i] = '0;
		add_message(0, 1'b0);
		add_message(1, 1'b0);
		for (int i = 0; i < 4; i++) begin
			req.data_byte = (i[0]) ? 8'hff : 8'h00;
			req.byte_present = 1'b1;
			req.end_of_message = (i == 3);
			pending_bytes.push_back(req);
		end
		pending_bytes.push_back('0);
		add_message(2, 1'b1);
		add_message(3, 1'b0);
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		add_message(55, 1'b0);
		add_message(56, 1'b0);
		add_message(64, 1'b1);
		add_message(119, 1'b0);
		while (pending_bytes.size() < 850) begin
			case ($urandom_range(0, 3))
				0: add_message($urandom_range(0, 8), $urandom_range(0, 1));
				1: add_message($urandom_range(50, 70), $urandom_range(0, 1));
				default: add_message($urandom_range(0, 130), $urandom_range(0, 1));
			endcase
		end
		wait (pending_bytes.size() == 0 && !s_axis_tvalid);
		wait (expected_digests.size() == 0);
		repeat (300) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	initial begin
		#20000000;
		$display("end of test: mismatches");
		$finish;
	end
endmodule
`default_nettype wire
